@@ rtl/spring_damper_force_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the spring damper force block
// Immediate-consequence and next-cycle implication checks, both gated by
// the active-low reset. Defining ASSERT_OFF turns every check into nothing.
// ----------------------------------------------------------------------------
`ifndef SPRING_DAMPER_FORCE_ASSERT_SVH
`define SPRING_DAMPER_FORCE_ASSERT_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent
`define SDF_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spring_damper_force: assertion failed");

// Consequent must hold in the cycle after the antecedent
`define SDF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spring_damper_force: assertion failed");

`else

`define SDF_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define SDF_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/sdf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared widths, register indexes and limits for the spring damper force
// datapath.
// ----------------------------------------------------------------------------
package sdf_pkg;

    // Fixed point format default
    localparam int FRAC_BITS_DEF = 16;

    // Port level widths
    localparam int DATA_W   = 32;
    localparam int IN_W     = 12 * DATA_W;
    localparam int OUT_W    = 3 * DATA_W;
    localparam int USER_W   = 2;
    localparam int ADDR_W   = 8;

    // Datapath widths
    localparam int DIF_W    = 33;   // coordinate difference, signed
    localparam int PROD_W   = 66;   // 33x33 product
    localparam int DOT_W    = 68;   // signed sum of three products
    localparam int DMAG_W   = 67;   // magnitude of the dot product
    localparam int LEN_W    = 33;   // floor sqrt of the squared length
    localparam int DQ_W     = 35;   // dot / len magnitude
    localparam int D_W      = 36;   // signed dot / len
    localparam int EXT_W    = 35;   // len - rest, signed
    localparam int PK_W     = 68;   // ks * (len - rest)
    localparam int PD_W     = 69;   // kd * d
    localparam int S_W      = 70;   // spring scalar, signed
    localparam int SPLIT    = 35;   // split point of the scalar magnitude
    localparam int PP_W     = 68;   // 35x33 partial product
    localparam int NUM_W    = 103;  // |s| * |L|
    localparam int FQ_W     = 33;   // force quotient bits

    // Saturation limits
    localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;
    localparam logic [FQ_W-1:0]   QMAX_POS = 33'h0_7FFF_FFFF;
    localparam logic [FQ_W-1:0]   QMAX_NEG = 33'h0_8000_0000;

    // Configuration register indexes
    typedef enum logic [ADDR_W-1:0] {
        REG_REST_LENGTH      = 8'd0,
        REG_SPRING_STIFFNESS = 8'd1,
        REG_DAMPING_COEFF    = 8'd2
    } cfg_reg_t;

endpackage

@@ rtl/sdf_sqrt_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_sqrt_pipe
// Pipelined digit-by-digit integer square root: one root bit per stage,
// floor result, with a pass-along tag that travels with each beat.
// ----------------------------------------------------------------------------
module sdf_sqrt_pipe #(
    parameter int RW = 33,
    parameter int TW = 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_vld,
    input  logic [2*RW-1:0] in_rad,
    input  logic [TW-1:0]   in_tag,
    output logic            out_vld,
    output logic [RW-1:0]   out_root,
    output logic [TW-1:0]   out_tag
);

    logic            vld_reg  [RW];
    logic [2*RW-1:0] rad_reg  [RW];
    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [TW-1:0]   tag_reg  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;

        logic            vld_in;
        logic [2*RW-1:0] rad_in;
        logic [RW+1:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic [TW-1:0]   tag_in;
        logic [RW+3:0]   rs;
        logic [RW+3:0]   trial;
        logic            ge;
        logic [RW+1:0]   rem_next;
        logic [RW-1:0]   root_next;

        if (k == 0) begin : g_head
            assign vld_in  = in_vld;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign tag_in  = in_tag;
        end else begin : g_body
            assign vld_in  = vld_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign tag_in  = tag_reg[k-1];
        end

        // bring down two radicand bits, try root*4+1
        always_comb begin
            rs        = {rem_in, rad_in[2*B+1 -: 2]};
            trial     = (RW+4)'({root_in, 2'b01});
            ge        = (rs >= trial);
            rem_next  = ge ? (RW+2)'(rs - trial) : rs[RW+1:0];
            root_next = {root_in[RW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= rad_in;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                tag_reg[k]  <= tag_in;
            end
        end
    end

    assign out_vld  = vld_reg[RW-1];
    assign out_root = root_reg[RW-1];
    assign out_tag  = tag_reg[RW-1];

endmodule

@@ rtl/sdf_div_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_div_pipe
// Pipelined unsigned restoring divider: an overflow check stage, then one
// quotient bit per stage. Quotient is valid when the overflow flag is clear.
// ----------------------------------------------------------------------------
module sdf_div_pipe #(
    parameter int NW = 67,
    parameter int DW = 33,
    parameter int QW = 35,
    parameter int TW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [TW-1:0] in_tag,
    output logic          out_vld,
    output logic [QW-1:0] out_quo,
    output logic          out_ovf,
    output logic [TW-1:0] out_tag
);

    localparam int CW = (NW > DW) ? NW : DW;

    logic          vld_reg [QW+1];
    logic [DW-1:0] rem_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic [QW-1:0] lo_reg  [QW+1];
    logic [QW-1:0] quo_reg [QW+1];
    logic          ovf_reg [QW+1];
    logic [TW-1:0] tag_reg [QW+1];

    // Head stage: upper numerator bits must stay below the divisor
    logic [CW-1:0] hi_w;
    logic          ovf_next;

    assign hi_w     = CW'(in_num) >> QW;
    assign ovf_next = (hi_w >= CW'(in_den));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= hi_w[DW-1:0];
            den_reg[0] <= in_den;
            lo_reg[0]  <= in_num[QW-1:0];
            quo_reg[0] <= '0;
            ovf_reg[0] <= ovf_next;
            tag_reg[0] <= in_tag;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 1; k <= QW; k++) begin : g_stage
        localparam int J = QW - k;

        logic [DW:0]   rs;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        always_comb begin
            rs       = {rem_reg[k-1], lo_reg[k-1][J]};
            ge       = (rs >= {1'b0, den_reg[k-1]});
            rem_next = ge ? DW'(rs - {1'b0, den_reg[k-1]}) : rs[DW-1:0];
            quo_next = quo_reg[k-1];
            quo_next[J] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_reg[k-1];
                lo_reg[k]  <= lo_reg[k-1];
                quo_reg[k] <= quo_next;
                ovf_reg[k] <= ovf_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_vld = vld_reg[QW];
    assign out_quo = quo_reg[QW];
    assign out_ovf = ovf_reg[QW];
    assign out_tag = tag_reg[QW];

endmodule

@@ rtl/spring_damper_force.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_damper_force
// Damped Hooke spring force on the first of two particles, signed fixed
// point, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless the result side stalls, and returns one
// result beat per input beat, in order. The pipeline holds the 33-stage
// square root, the 36-stage division of the dot product by the length and
// the 34-stage force division (three lanes side by side); the rest is
// difference, product, sum and output stages. A stall on the result side
// freezes the whole pipeline, so s_tready follows m_tready whenever a
// result is waiting. Configuration registers are read live by the pipeline
// and are meant to be written while no beat is in flight. Coincident
// particles give a zero force with tuser bit 0 set; any clamped component
// sets tuser bit 1 unless the particles coincide.
// ----------------------------------------------------------------------------
`include "spring_damper_force_assert.svh"

module spring_damper_force #(
    parameter int FRAC_BITS = sdf_pkg::FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sdf_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [sdf_pkg::DATA_W-1:0] cfg_data,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
    // vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z (32 bits each)
    input  logic [sdf_pkg::IN_W-1:0]   s_tdata,
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // force_x, force_y, force_z (32 bits each)
    output logic [sdf_pkg::OUT_W-1:0]  m_tdata,
    // zero_length, saturated
    output logic [sdf_pkg::USER_W-1:0] m_tuser
);

    import sdf_pkg::*;

    localparam int DEN_W = LEN_W + FRAC_BITS;
    localparam logic [DATA_W-1:0] REST_RESET = DATA_W'(1) << FRAC_BITS;

    // pipeline advance: output register free or being drained
    logic en;
    logic m_tvalid_reg;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0] rest_length_reg;
    logic [DATA_W-1:0] spring_stiffness_reg;
    logic [DATA_W-1:0] damping_coefficient_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rest_length_reg         <= REST_RESET;
            spring_stiffness_reg    <= '0;
            damping_coefficient_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_REST_LENGTH:      rest_length_reg         <= cfg_data;
                REG_SPRING_STIFFNESS: spring_stiffness_reg    <= cfg_data;
                REG_DAMPING_COEFF:    damping_coefficient_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // stage A: separation and relative velocity
    // ------------------------------------------------------------------------
    logic                    a_vld_reg;
    logic signed [DIF_W-1:0] a_l_reg [3];
    logic signed [DIF_W-1:0] a_v_reg [3];
    logic signed [DIF_W-1:0] a_l_next [3];
    logic signed [DIF_W-1:0] a_v_next [3];

    always_comb begin
        logic [DATA_W-1:0] pa, pb, va, vb;
        for (int i = 0; i < 3; i++) begin
            pa = s_tdata[DATA_W*i +: DATA_W];
            pb = s_tdata[DATA_W*(3+i) +: DATA_W];
            va = s_tdata[DATA_W*(6+i) +: DATA_W];
            vb = s_tdata[DATA_W*(9+i) +: DATA_W];
            a_l_next[i] = $signed({pa[DATA_W-1], pa}) - $signed({pb[DATA_W-1], pb});
            a_v_next[i] = $signed({va[DATA_W-1], va}) - $signed({vb[DATA_W-1], vb});
        end
    end

    // ------------------------------------------------------------------------
    // stage B: squares and dot terms
    // ------------------------------------------------------------------------
    logic                     b_vld_reg;
    logic signed [PROD_W-1:0] b_sq_reg [3];
    logic signed [PROD_W-1:0] b_dp_reg [3];
    logic signed [DIF_W-1:0]  b_l_reg  [3];

    // ------------------------------------------------------------------------
    // stage C: squared length, dot product magnitude, coincidence
    // ------------------------------------------------------------------------
    logic                    c_vld_reg;
    logic [PROD_W-1:0]       c_sq_reg;
    logic [DMAG_W-1:0]       c_dmag_reg;
    logic                    c_dneg_reg;
    logic signed [DIF_W-1:0] c_l_reg [3];
    logic                    c_zero_reg;

    logic [PROD_W-1:0]       c_sq_next;
    logic signed [DOT_W-1:0] c_dot;

    assign c_sq_next = PROD_W'(b_sq_reg[0]) + PROD_W'(b_sq_reg[1]) + PROD_W'(b_sq_reg[2]);
    assign c_dot     = DOT_W'(b_dp_reg[0]) + DOT_W'(b_dp_reg[1]) + DOT_W'(b_dp_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_tvalid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                a_l_reg[i]  <= a_l_next[i];
                a_v_reg[i]  <= a_v_next[i];
                b_sq_reg[i] <= a_l_reg[i] * a_l_reg[i];
                b_dp_reg[i] <= a_v_reg[i] * a_l_reg[i];
                b_l_reg[i]  <= a_l_reg[i];
                c_l_reg[i]  <= b_l_reg[i];
            end
            c_sq_reg   <= c_sq_next;
            c_dneg_reg <= c_dot[DOT_W-1];
            c_dmag_reg <= c_dot[DOT_W-1] ? DMAG_W'(-c_dot) : DMAG_W'(c_dot);
            c_zero_reg <= (b_l_reg[0] == '0) && (b_l_reg[1] == '0) && (b_l_reg[2] == '0);
        end
    end

    // ------------------------------------------------------------------------
    // square root of the squared length
    // ------------------------------------------------------------------------
    localparam int SQT_W = DMAG_W + 1 + 3*DIF_W + 1;

    logic             sq_vld;
    logic [LEN_W-1:0] sq_root;
    logic [SQT_W-1:0] sq_tag;

    sdf_sqrt_pipe #(
        .RW (LEN_W),
        .TW (SQT_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (c_vld_reg),
        .in_rad   (c_sq_reg),
        .in_tag   ({c_dmag_reg, c_dneg_reg, c_l_reg[2], c_l_reg[1], c_l_reg[0], c_zero_reg}),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_tag  (sq_tag)
    );

    // ------------------------------------------------------------------------
    // dot / len
    // ------------------------------------------------------------------------
    localparam int DDT_W = LEN_W + 1 + 3*DIF_W + 1;

    logic             dd_vld;
    logic [DQ_W-1:0]  dd_quo;
    logic             dd_ovf;
    logic [DDT_W-1:0] dd_tag;

    sdf_div_pipe #(
        .NW (DMAG_W),
        .DW (LEN_W),
        .QW (DQ_W),
        .TW (DDT_W)
    ) u_div_dot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (sq_vld),
        .in_num  (sq_tag[SQT_W-1 -: DMAG_W]),
        .in_den  (sq_root),
        .in_tag  ({sq_root, sq_tag[SQT_W-DMAG_W-1:0]}),
        .out_vld (dd_vld),
        .out_quo (dd_quo),
        .out_ovf (dd_ovf),
        .out_tag (dd_tag)
    );

    logic [LEN_W-1:0]        dd_len;
    logic                    dd_neg;
    logic signed [DIF_W-1:0] dd_l [3];
    logic                    dd_zero;

    assign dd_len  = dd_tag[DDT_W-1 -: LEN_W];
    assign dd_neg  = dd_tag[3*DIF_W+1];
    assign dd_l[2] = dd_tag[3*DIF_W -: DIF_W];
    assign dd_l[1] = dd_tag[2*DIF_W -: DIF_W];
    assign dd_l[0] = dd_tag[DIF_W -: DIF_W];
    assign dd_zero = dd_tag[0];

    // ------------------------------------------------------------------------
    // stages E1..E5: spring scalar and force numerators
    // ------------------------------------------------------------------------
    logic                    e1_vld_reg, e2_vld_reg, e3_vld_reg, e4_vld_reg, e5_vld_reg;
    logic signed [D_W-1:0]   e1_d_reg;
    logic signed [EXT_W-1:0] e1_ext_reg;
    logic signed [PK_W-1:0]  e2_pk_reg;
    logic signed [PD_W-1:0]  e2_pd_reg;
    logic [S_W-1:0]          e3_smag_reg;
    logic                    e3_sneg_reg;
    logic [DIF_W-1:0]        e3_lmag_reg [3];
    logic [PP_W-1:0]         e4_plo_reg [3];
    logic [PP_W-1:0]         e4_phi_reg [3];
    logic [NUM_W-1:0]        e5_num_reg [3];
    logic                    e4_neg_reg [3];
    logic                    e5_neg_reg [3];
    logic signed [DIF_W-1:0] e1_l_reg [3];
    logic signed [DIF_W-1:0] e2_l_reg [3];
    logic [LEN_W-1:0]        e1_len_reg, e2_len_reg, e3_len_reg, e4_len_reg, e5_len_reg;
    logic                    e1_zero_reg, e2_zero_reg, e3_zero_reg, e4_zero_reg, e5_zero_reg;
    logic                    e3_lneg_reg [3];

    logic signed [S_W-1:0]   e3_s;

    assign e3_s = S_W'(e2_pk_reg) + S_W'(e2_pd_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            e3_vld_reg <= 1'b0;
            e4_vld_reg <= 1'b0;
            e5_vld_reg <= 1'b0;
        end else if (en) begin
            e1_vld_reg <= dd_vld;
            e2_vld_reg <= e1_vld_reg;
            e3_vld_reg <= e2_vld_reg;
            e4_vld_reg <= e3_vld_reg;
            e5_vld_reg <= e4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // E1: signed quotient and length error
            e1_d_reg   <= dd_neg ? -$signed({1'b0, dd_quo}) : $signed({1'b0, dd_quo});
            e1_ext_reg <= $signed({2'b00, dd_len}) - $signed({3'b000, rest_length_reg});
            // E2: stiffness and damping products
            e2_pk_reg  <= $signed({1'b0, spring_stiffness_reg}) * e1_ext_reg;
            e2_pd_reg  <= $signed({1'b0, damping_coefficient_reg}) * e1_d_reg;
            // E3: scalar magnitude and sign
            e3_sneg_reg <= e3_s[S_W-1];
            e3_smag_reg <= e3_s[S_W-1] ? S_W'(-e3_s) : S_W'(e3_s);
            for (int i = 0; i < 3; i++) begin
                e1_l_reg[i]    <= dd_l[i];
                e2_l_reg[i]    <= e1_l_reg[i];
                e3_lneg_reg[i] <= e2_l_reg[i][DIF_W-1];
                e3_lmag_reg[i] <= e2_l_reg[i][DIF_W-1] ? DIF_W'(-e2_l_reg[i])
                                                       : DIF_W'(e2_l_reg[i]);
                // E4: split partial products
                e4_plo_reg[i] <= PP_W'(e3_smag_reg[SPLIT-1:0]) * PP_W'(e3_lmag_reg[i]);
                e4_phi_reg[i] <= PP_W'(e3_smag_reg[S_W-1:SPLIT]) * PP_W'(e3_lmag_reg[i]);
                e4_neg_reg[i] <= (e3_sneg_reg == e3_lneg_reg[i]);
                // E5: recombine
                e5_num_reg[i] <= NUM_W'(e4_plo_reg[i]) + (NUM_W'(e4_phi_reg[i]) << SPLIT);
                e5_neg_reg[i] <= e4_neg_reg[i];
            end
            e1_len_reg  <= dd_len;
            e2_len_reg  <= e1_len_reg;
            e3_len_reg  <= e2_len_reg;
            e4_len_reg  <= e3_len_reg;
            e5_len_reg  <= e4_len_reg;
            e1_zero_reg <= dd_zero;
            e2_zero_reg <= e1_zero_reg;
            e3_zero_reg <= e2_zero_reg;
            e4_zero_reg <= e3_zero_reg;
            e5_zero_reg <= e4_zero_reg;
        end
    end

    // ------------------------------------------------------------------------
    // force division, three lanes
    // ------------------------------------------------------------------------
    logic [DEN_W-1:0] f_den;
    logic             fd_vld [3];
    logic [FQ_W-1:0]  fd_quo [3];
    logic             fd_ovf [3];
    logic [1:0]       fd_tag [3];

    assign f_den = DEN_W'(e5_len_reg) << FRAC_BITS;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        sdf_div_pipe #(
            .NW (NUM_W),
            .DW (DEN_W),
            .QW (FQ_W),
            .TW (2)
        ) u_div_force (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_vld  (e5_vld_reg),
            .in_num  (e5_num_reg[i]),
            .in_den  (f_den),
            .in_tag  ({e5_neg_reg[i], e5_zero_reg}),
            .out_vld (fd_vld[i]),
            .out_quo (fd_quo[i]),
            .out_ovf (fd_ovf[i]),
            .out_tag (fd_tag[i])
        );
    end

    // ------------------------------------------------------------------------
    // output register: sign, clamp, coincidence override
    // ------------------------------------------------------------------------
    logic [OUT_W-1:0]  m_tdata_reg,  m_tdata_next;
    logic [USER_W-1:0] m_tuser_reg,  m_tuser_next;

    always_comb begin
        logic [FQ_W-1:0]   q;
        logic              sat_i;
        logic              sat_any;
        logic [DATA_W-1:0] f;
        logic              zero;
        sat_any = 1'b0;
        zero    = fd_tag[0][0];
        m_tdata_next = '0;
        for (int i = 0; i < 3; i++) begin
            q = fd_quo[i];
            if (fd_tag[i][1]) begin
                sat_i = fd_ovf[i] || (q > QMAX_NEG);
                f     = sat_i ? SAT_NEG : DATA_W'(~q + 1'b1);
            end else begin
                sat_i = fd_ovf[i] || (q > QMAX_POS);
                f     = sat_i ? SAT_POS : q[DATA_W-1:0];
            end
            sat_any = sat_any | sat_i;
            m_tdata_next[DATA_W*i +: DATA_W] = zero ? '0 : f;
        end
        m_tuser_next = {sat_any & ~zero, zero};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= fd_vld[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `SDF_ASSERT_IMPLY(a_zero_force, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0)
    `SDF_ASSERT_IMPLY(a_sat_clamped, aclk, aresetn, m_tvalid && m_tuser[1],
        m_tdata[31:0] == SAT_POS || m_tdata[31:0] == SAT_NEG ||
        m_tdata[63:32] == SAT_POS || m_tdata[63:32] == SAT_NEG ||
        m_tdata[95:64] == SAT_POS || m_tdata[95:64] == SAT_NEG)
    `SDF_ASSERT_IMPLY(a_lanes_agree, aclk, aresetn, 1'b1,
        fd_vld[0] == fd_vld[1] && fd_vld[0] == fd_vld[2] &&
        (!fd_vld[0] || (fd_tag[0][0] == fd_tag[1][0] && fd_tag[0][0] == fd_tag[2][0])))
    `SDF_ASSERT_IMPLY(a_dot_quo_fits, aclk, aresetn, dd_vld && !dd_zero, !dd_ovf)
    `SDF_ASSERT_NEXT(a_cfg_ks_write, aclk, aresetn,
        cfg_valid && cfg_ready && cfg_addr == REG_SPRING_STIFFNESS,
        spring_stiffness_reg == $past(cfg_data))

endmodule
